>>> rtl/rgb_luma_gain_pixel_assert.svh
// Assertion macros shared by the RTL of the luma gain pixel block
`ifndef RGB_LUMA_GAIN_PIXEL_ASSERT_SVH
`define RGB_LUMA_GAIN_PIXEL_ASSERT_SVH

// Check a consequence in the same cycle as its condition
`define RLG_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Check a consequence in the cycle after its condition
`define RLG_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/rlg_pkg.sv
// Types, coefficients and rounding helper for the luma gain pixel block
`default_nettype none

package rlg_pkg;

  // Forward transform coefficients, Q2.10
  localparam logic [19:0] KY_R   = 20'd263;
  localparam logic [19:0] KY_G   = 20'd516;
  localparam logic [19:0] KY_B   = 20'd100;
  localparam logic [19:0] KU_R   = 20'd152;
  localparam logic [19:0] KU_G   = 20'd298;
  localparam logic [19:0] KU_B   = 20'd450;
  localparam logic [19:0] KV_R   = 20'd450;
  localparam logic [19:0] KV_G   = 20'd377;
  localparam logic [19:0] KV_B   = 20'd73;
  localparam logic [19:0] Y_BIAS = 20'd16384;
  localparam logic [19:0] UV_BIAS = 20'd131072;

  // Inverse transform coefficients, Q2.10
  localparam int unsigned AccW = 22;
  localparam logic signed [AccW-1:0] KI_Y  = 22'sd1192;
  localparam logic signed [AccW-1:0] KI_RV = 22'sd1634;
  localparam logic signed [AccW-1:0] KI_GV = 22'sd833;
  localparam logic signed [AccW-1:0] KI_GU = 22'sd400;
  localparam logic signed [AccW-1:0] KI_BU = 22'sd2066;

  // Offsets removed before the inverse transform
  localparam logic signed [8:0] Y_OFS  = 9'sd16;
  localparam logic signed [8:0] UV_OFS = 9'sd128;

  // Register indexes on the configuration port
  localparam logic REG_GAIN   = 1'b0;
  localparam logic REG_OFFSET = 1'b1;

  localparam logic [11:0] GAIN_RESET   = 12'd384;
  localparam logic [8:0]  OFFSET_RESET = 9'd0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [17:0] y;
    logic [17:0] u;
    logic [17:0] v;
  } yuv_acc_t;

  typedef struct packed {
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
  } yuv8_t;

  typedef struct packed {
    logic signed [AccW-1:0] t;
    logic [7:0]             u;
    logic [7:0]             v;
  } luma_t;

  typedef struct packed {
    logic signed [AccW-1:0] yc;
    logic signed [AccW-1:0] rv;
    logic signed [AccW-1:0] gv;
    logic signed [AccW-1:0] gu;
    logic signed [AccW-1:0] bu;
  } prod_t;

  typedef struct packed {
    logic [11:0]       gain;
    logic signed [8:0] offset;
  } cfg_t;

  // Round a Q.10 accumulator to nearest, ties to even, clamp to 0..255
  function automatic logic [7:0] round_clamp(input logic signed [AccW-1:0] acc);
    logic [AccW-11:0] q;
    logic [9:0]       rem;
    logic [AccW-10:0] qr;
    logic             up;
    q   = acc[AccW-1:10];
    rem = acc[9:0];
    up  = (rem > 10'd512) || ((rem == 10'd512) && q[0]);
    qr  = {1'b0, q} + {{(AccW-10){1'b0}}, up};
    if (acc <= 0) begin
      return 8'd0;
    end else if (qr > (AccW-9)'(255)) begin
      return 8'd255;
    end else begin
      return qr[7:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/rlg_apb.sv
// Configuration registers behind the APB-style port
`default_nettype none

module rlg_apb (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel_i,
  input  wire logic          penable_i,
  input  wire logic          pwrite_i,
  input  wire logic [2:0]    paddr_i,
  input  wire logic [31:0]   pwdata_i,
  output logic [31:0]        prdata_o,
  output rlg_pkg::cfg_t      cfg_o
);

  logic [11:0] gain_q;
  logic [8:0]  offset_q;
  logic        wr_en;
  logic        reg_sel;

  // Decode the word index and the access phase
  assign reg_sel = paddr_i[2];
  assign wr_en   = psel_i & penable_i & pwrite_i;

  // Write the registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= rlg_pkg::GAIN_RESET;
      offset_q <= rlg_pkg::OFFSET_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        rlg_pkg::REG_GAIN:   gain_q   <= pwdata_i[11:0];
        rlg_pkg::REG_OFFSET: offset_q <= pwdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Return the selected register on reads
  always_comb begin
    case (reg_sel)
      rlg_pkg::REG_GAIN:   prdata_o = {20'd0, gain_q};
      rlg_pkg::REG_OFFSET: prdata_o = {23'd0, offset_q};
      default:             prdata_o = 32'd0;
    endcase
  end

  assign cfg_o.gain   = gain_q;
  assign cfg_o.offset = $signed(offset_q);

endmodule

`default_nettype wire

>>> rtl/rlg_fwd.sv
// Forward RGB to YUV transform: products and sums, then rounding
`default_nettype none

module rlg_fwd (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  rlg_pkg::pix_t       pix_i,
  output logic                acc_valid_o,
  output logic                valid_o,
  output rlg_pkg::yuv8_t      yuv_o
);

  logic [19:0]       r_w, g_w, b_w;
  logic [19:0]       y_sum, u_sum, v_sum;
  rlg_pkg::yuv_acc_t acc_d, acc_q;
  rlg_pkg::yuv8_t    yuv_d, yuv_q;
  logic              v1_q, v2_q;

  // Form the three weighted sums; all stay positive for 8-bit inputs
  always_comb begin
    r_w   = 20'(pix_i.red);
    g_w   = 20'(pix_i.green);
    b_w   = 20'(pix_i.blue);
    y_sum = rlg_pkg::KY_R * r_w + rlg_pkg::KY_G * g_w + rlg_pkg::KY_B * b_w
          + rlg_pkg::Y_BIAS;
    u_sum = rlg_pkg::KU_B * b_w + rlg_pkg::UV_BIAS - rlg_pkg::KU_R * r_w
          - rlg_pkg::KU_G * g_w;
    v_sum = rlg_pkg::KV_R * r_w + rlg_pkg::UV_BIAS - rlg_pkg::KV_G * g_w
          - rlg_pkg::KV_B * b_w;
    acc_d.y = y_sum[17:0];
    acc_d.u = u_sum[17:0];
    acc_d.v = v_sum[17:0];
  end

  // Round and clamp each channel
  always_comb begin
    yuv_d.y = rlg_pkg::round_clamp($signed(22'(acc_q.y)));
    yuv_d.u = rlg_pkg::round_clamp($signed(22'(acc_q.u)));
    yuv_d.v = rlg_pkg::round_clamp($signed(22'(acc_q.v)));
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // Advance the data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= acc_d;
      yuv_q <= yuv_d;
    end
  end

  assign acc_valid_o = v1_q;
  assign valid_o     = v2_q;
  assign yuv_o       = yuv_q;

endmodule

`default_nettype wire

>>> rtl/rlg_luma.sv
// Luma gain and offset, then the inverse transform products
`default_nettype none

module rlg_luma (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  rlg_pkg::yuv8_t      yuv_i,
  input  rlg_pkg::cfg_t       cfg_i,
  output logic                luma_valid_o,
  output logic                valid_o,
  output rlg_pkg::prod_t      prod_o
);

  logic [19:0]            gain_prod;
  rlg_pkg::luma_t         luma_d, luma_q;
  logic [7:0]             y_adj;
  logic signed [8:0]      c_w, d_w, e_w;
  rlg_pkg::prod_t         prod_d, prod_q;
  logic                   v3_q, v4_q;

  // Scale luma and add the offset in Q.8
  always_comb begin
    gain_prod = 20'(yuv_i.y) * 20'(cfg_i.gain);
    luma_d.t  = $signed({2'b00, gain_prod})
              + $signed({{5{cfg_i.offset[8]}}, cfg_i.offset, 8'h00});
    luma_d.u  = yuv_i.u;
    luma_d.v  = yuv_i.v;
  end

  // Truncate, clamp and remove the offsets
  always_comb begin
    if (luma_q.t <= 0) begin
      y_adj = 8'd0;
    end else if (luma_q.t[21:8] > 14'd255) begin
      y_adj = 8'd255;
    end else begin
      y_adj = luma_q.t[15:8];
    end
    c_w = $signed({1'b0, y_adj}) - rlg_pkg::Y_OFS;
    d_w = $signed({1'b0, luma_q.u}) - rlg_pkg::UV_OFS;
    e_w = $signed({1'b0, luma_q.v}) - rlg_pkg::UV_OFS;
    prod_d.yc = 22'(c_w) * rlg_pkg::KI_Y;
    prod_d.rv = 22'(e_w) * rlg_pkg::KI_RV;
    prod_d.gv = 22'(e_w) * rlg_pkg::KI_GV;
    prod_d.gu = 22'(d_w) * rlg_pkg::KI_GU;
    prod_d.bu = 22'(d_w) * rlg_pkg::KI_BU;
  end

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= valid_i;
      v4_q <= v3_q;
    end
  end

  // Advance the data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      luma_q <= luma_d;
      prod_q <= prod_d;
    end
  end

  assign luma_valid_o = v3_q;
  assign valid_o      = v4_q;
  assign prod_o       = prod_q;

endmodule

`default_nettype wire

>>> rtl/rlg_inv.sv
// Inverse transform sums, rounding and the output register
`default_nettype none

module rlg_inv (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  rlg_pkg::prod_t      prod_i,
  output logic                valid_o,
  output rlg_pkg::pix_t       pix_o
);

  logic signed [rlg_pkg::AccW-1:0] r_acc, g_acc, b_acc;
  rlg_pkg::pix_t                   pix_d, pix_q;
  logic                            v5_q;

  // Sum the products and round each channel
  always_comb begin
    r_acc       = prod_i.yc + prod_i.rv;
    g_acc       = prod_i.yc - prod_i.gv - prod_i.gu;
    b_acc       = prod_i.yc + prod_i.bu;
    pix_d.red   = rlg_pkg::round_clamp(r_acc);
    pix_d.green = rlg_pkg::round_clamp(g_acc);
    pix_d.blue  = rlg_pkg::round_clamp(b_acc);
  end

  // Hold the output word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix_q <= pix_d;
    end
  end

  assign valid_o = v5_q;
  assign pix_o   = pix_q;

endmodule

`default_nettype wire

>>> rtl/rgb_luma_gain_pixel.sv
// An accepted input word moves through the acc, yuv, luma, prod and output registers in that order.
// Throughput: one word per cycle while the output is not stalled; five register stages move together.
// A stalled output word freezes every stage, so nothing is lost or repeated.
// Reset clears all stage valid bits and sets gain to 384 (1.5) and offset to 0.
`default_nettype none

`include "rgb_luma_gain_pixel_assert.svh"

module rgb_luma_gain_pixel (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_red_i,
  input  wire logic [7:0]  in_green_i,
  input  wire logic [7:0]  in_blue_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_red_o,
  output logic [7:0]       out_green_o,
  output logic [7:0]       out_blue_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic           pipe_en;
  rlg_pkg::pix_t  in_pix, out_pix;
  rlg_pkg::yuv8_t yuv;
  rlg_pkg::prod_t prod;
  rlg_pkg::cfg_t  cfg;
  logic           s1_valid, s2_valid, s3_valid, s4_valid;

  // Advance the whole pipeline unless the output word is stuck
  assign pipe_en    = !out_valid_o || out_ready_i;
  assign in_ready_o = pipe_en;
  assign pready     = 1'b1;

  assign in_pix.red   = in_red_i;
  assign in_pix.green = in_green_i;
  assign in_pix.blue  = in_blue_i;

  rlg_apb u_apb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  rlg_fwd u_fwd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (pipe_en),
    .valid_i     (in_valid_i),
    .pix_i       (in_pix),
    .acc_valid_o (s1_valid),
    .valid_o     (s2_valid),
    .yuv_o       (yuv)
  );

  rlg_luma u_luma (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (pipe_en),
    .valid_i      (s2_valid),
    .yuv_i        (yuv),
    .cfg_i        (cfg),
    .luma_valid_o (s3_valid),
    .valid_o      (s4_valid),
    .prod_o       (prod)
  );

  rlg_inv u_inv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s4_valid),
    .prod_i  (prod),
    .valid_o (out_valid_o),
    .pix_o   (out_pix)
  );

  assign out_red_o   = out_pix.red;
  assign out_green_o = out_pix.green;
  assign out_blue_o  = out_pix.blue;

  // Stage valid bits freeze while the output stalls
  `RLG_ASSERT_NEXT(a_stall_freeze, clk_i, rst_ni, !pipe_en,
    $stable({s1_valid, s2_valid, s3_valid, s4_valid, out_valid_o}),
    "pipeline moved during a stall")

  // An accepted word occupies the first stage
  `RLG_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, in_valid_i && in_ready_o,
    s1_valid, "accepted word missing from first stage")

  // A word in the last product stage reaches the output when the pipe moves
  `RLG_ASSERT_NEXT(a_reach_out, clk_i, rst_ni, pipe_en && s4_valid,
    out_valid_o, "word lost before the output register")

  // A gain write lands in the register
  `RLG_ASSERT_NEXT(a_gain_write, clk_i, rst_ni,
    psel && penable && pwrite && (paddr[2] == rlg_pkg::REG_GAIN),
    cfg.gain == $past(pwdata[11:0]), "gain write not taken")

endmodule

`default_nettype wire
